>>> sv/otahc_pkg.sv
// ----------------------------------------------------------------------------
// otahc_pkg
// Shared types and constants for the outside temperature average and
// heating curve block.
// ----------------------------------------------------------------------------
package otahc_pkg;

	// Field widths.
	localparam int TEMP_W = 8;
	localparam int WIN_W  = 6;

	// History of half-hour samples.
	localparam int HISTORY_DEPTH = 96;
	localparam int HAW  = $clog2(HISTORY_DEPTH);
	localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
	// Signed sum of up to HISTORY_DEPTH samples, and its magnitude.
	localparam int SUMW = CNTW + TEMP_W;
	localparam int MAGW = SUMW - 1;
	localparam int DCW  = $clog2(MAGW);

	// Heating curve.
	localparam int CURVE_SIZE = 36;
	localparam int CURVE_IW   = $clog2(CURVE_SIZE);
	localparam int CURVE_LAST = 35;
	localparam int CURVE_OFS  = 20;
	localparam int AVG_HI     = 15;
	localparam int AVG_LO     = -20;

	// Configuration reset value.
	localparam int WIN_RESET = 12;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	// One unit of work for the back end.
	typedef struct packed {
		logic                       is_curve;
		logic signed [TEMP_W-1:0]   temp;
		logic [CURVE_IW-1:0]        idx;
		logic signed [TEMP_W-1:0]   val;
	} work_item_t;

	// Front to queue.
	typedef struct packed {
		logic       push;
		work_item_t item;
	} work_push_t;

	// Queue to back.
	typedef struct packed {
		logic       valid;
		work_item_t item;
	} work_head_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ACCUM,
		BK_DIV,
		BK_LOOK,
		BK_RESULT
	} back_state_t;

endpackage

>>> sv/otahc_in_if.sv
// ----------------------------------------------------------------------------
// otahc_in_if
// Input channel: temperature samples and heating curve writes.
// ----------------------------------------------------------------------------
interface otahc_in_if import otahc_pkg::*;;

	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic                       reads_valid;
	logic signed [TEMP_W-1:0]   outside_temp;
	logic [CURVE_IW-1:0]        entry_index;
	logic signed [TEMP_W-1:0]   entry_value;

	modport source (
		output valid, mode, reads_valid, outside_temp, entry_index, entry_value,
		input  ready
	);

	modport sink (
		input  valid, mode, reads_valid, outside_temp, entry_index, entry_value,
		output ready
	);

endinterface

>>> sv/otahc_out_if.sv
// ----------------------------------------------------------------------------
// otahc_out_if
// Output channel: window average and heat request.
// ----------------------------------------------------------------------------
interface otahc_out_if import otahc_pkg::*;;

	logic                       valid;
	logic                       ready;
	logic signed [TEMP_W-1:0]   average_temp;
	logic signed [TEMP_W-1:0]   heat_request;

	modport source (
		output valid, average_temp, heat_request,
		input  ready
	);

	modport sink (
		input  valid, average_temp, heat_request,
		output ready
	);

endinterface

>>> sv/outside_temp_avg_heat_curve_core.sv
// ----------------------------------------------------------------------------
// outside_temp_avg_heat_curve_core
// Outside temperature window average driving a weather compensated
// heating curve.
// ----------------------------------------------------------------------------
// Window: a valid sample is averaged over 2*W history entries, W the window
//   in hours (zero counts as one, 2*W capped at 96).
// Samples: the back end starts one only when done with the last, after the
//   serial window sum (one history read per cycle) and 14-step divider.
// Reset: window 12 hours, curve entries read as zero, history empty; the
//   first valid sample stands for the whole history. No clearing pass.
module outside_temp_avg_heat_curve_core import otahc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [WIN_W-1:0]    cfg_data,
	otahc_in_if.sink            in_ch,
	otahc_out_if.source         out_ch
);

	work_push_t         q_push;
	work_head_t         q_head;
	logic               q_full;
	logic               q_pop;
	logic [WIN_W-1:0]   window_hours;

	// Item intake and window register.
	otahc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_ch        (in_ch),
		.q_full       (q_full),
		.q_push       (q_push),
		.window_hours (window_hours)
	);

	// Work queue.
	otahc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_head (q_head)
	);

	// Averaging, division and curve lookup.
	otahc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_hours (window_hours),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_ch       (out_ch)
	);

endmodule

>>> sv/otahc_front.sv
// ----------------------------------------------------------------------------
// otahc_front
// Accepts items, drops those that do nothing, and queues the rest. Also
// holds the averaging window register.
// ----------------------------------------------------------------------------
module otahc_front import otahc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [WIN_W-1:0]    cfg_data,
	otahc_in_if.sink            in_ch,
	input  logic                q_full,
	output work_push_t          q_push,
	output logic [WIN_W-1:0]    window_hours
);

	logic [WIN_W-1:0] window_hours_q;
	logic             accept;
	logic             useful;

	// Window register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_hours_q <= WIN_W'(WIN_RESET);
		end else if (cfg_valid) begin
			window_hours_q <= cfg_data;
		end
	end

	assign window_hours = window_hours_q;

	// Take an item whenever the queue has room.
	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Invalid samples and out-of-range curve writes are dropped here.
	always_comb begin
		if (in_ch.mode) begin
			useful = (in_ch.entry_index < CURVE_IW'(CURVE_SIZE));
		end else begin
			useful = in_ch.reads_valid;
		end
	end

	// Build the queue entry.
	always_comb begin
		q_push.push          = accept && useful;
		q_push.item.is_curve = in_ch.mode;
		q_push.item.temp     = in_ch.outside_temp;
		q_push.item.idx      = in_ch.entry_index;
		q_push.item.val      = in_ch.entry_value;
	end

endmodule

>>> sv/otahc_queue.sv
// ----------------------------------------------------------------------------
// otahc_queue
// Short FIFO of work items between the front and the back.
// ----------------------------------------------------------------------------
module otahc_queue import otahc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  work_push_t  q_push,
	output logic        q_full,
	input  logic        q_pop,
	output work_head_t  q_head
);

	work_item_t         slot_q [QUEUE_DEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QCW-1:0]     level_q;
	logic               do_push;
	logic               do_pop;

	assign q_full  = (level_q == QCW'(QUEUE_DEPTH));
	assign do_push = q_push.push && !q_full;
	assign do_pop  = q_pop && (level_q != '0);

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_push.item;
		end
	end

	assign q_head.valid = (level_q != '0);
	assign q_head.item  = slot_q[rd_ptr_q];

endmodule

>>> sv/otahc_back.sv
// ----------------------------------------------------------------------------
// otahc_back
// Carries out queued items: keeps the sample history and the heating curve,
// sums the window serially, divides bit by bit and looks up the curve.
// ----------------------------------------------------------------------------
module otahc_back import otahc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [WIN_W-1:0]    window_hours,
	input  work_head_t          q_head,
	output logic                q_pop,
	otahc_out_if.source         out_ch
);

	back_state_t                state_q;
	back_state_t                state_d;

	// Sequencer strobes.
	logic                       issue;
	logic                       div_init;
	logic                       div_step;
	logic                       look;
	logic                       load_out;
	logic                       take_sample;
	logic                       take_curve;

	// History, kept as a circular buffer.
	logic signed [TEMP_W-1:0]   hist_mem [HISTORY_DEPTH];
	logic [HAW-1:0]             wptr_q;
	logic [HAW-1:0]             rd_ptr_q;
	logic [CNTW-1:0]            filled_q;
	logic signed [TEMP_W-1:0]   first_val_q;

	// Window summation.
	logic [CNTW-1:0]            count_d;
	logic [CNTW-1:0]            count_q;
	logic [CNTW-1:0]            iss_q;
	logic                       rd_vld_s1;
	logic                       use_first_s1;
	logic signed [TEMP_W-1:0]   hist_rd_s1;
	logic signed [TEMP_W-1:0]   add_val;
	logic signed [SUMW-1:0]     sum_q;

	// Divider.
	logic [MAGW-1:0]            quo_q;
	logic [CNTW-1:0]            rem_q;
	logic                       neg_q;
	logic [DCW-1:0]             div_cnt_q;
	logic [CNTW:0]              rem_sh;
	logic                       rem_ge;

	// Curve lookup.
	logic signed [TEMP_W-1:0]   curve_mem [CURVE_SIZE];
	logic [CURVE_SIZE-1:0]      curve_vld_q;
	logic signed [TEMP_W-1:0]   curve_rd_s1;
	logic                       curve_rv_s1;
	logic [TEMP_W-1:0]          avg_mag;
	logic signed [TEMP_W-1:0]   avg_d;
	logic signed [TEMP_W-1:0]   avg_q;
	logic signed [TEMP_W-1:0]   ofs_sum;
	logic [CURVE_IW-1:0]        cidx;

	// Output register.
	logic                       out_valid_q;
	logic signed [TEMP_W-1:0]   average_temp_q;
	logic signed [TEMP_W-1:0]   heat_request_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_head.valid && !q_head.item.is_curve) begin
					state_d = BK_ACCUM;
				end
			end
			BK_ACCUM: begin
				if (div_init) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_cnt_q == DCW'(MAGW - 1)) begin
					state_d = BK_LOOK;
				end
			end
			BK_LOOK: begin
				state_d = BK_RESULT;
			end
			BK_RESULT: begin
				if (load_out) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		q_pop    = 1'b0;
		issue    = 1'b0;
		div_init = 1'b0;
		div_step = 1'b0;
		look     = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop = q_head.valid;
			end
			BK_ACCUM: begin
				issue    = (iss_q != count_q);
				div_init = (iss_q == count_q) && !rd_vld_s1;
			end
			BK_DIV: begin
				div_step = 1'b1;
			end
			BK_LOOK: begin
				look = 1'b1;
			end
			BK_RESULT: begin
				load_out = !out_valid_q || out_ch.ready;
			end
			default: begin
			end
		endcase
	end

	assign take_sample = q_pop && !q_head.item.is_curve;
	assign take_curve  = q_pop && q_head.item.is_curve;

	// Samples in the window: two per hour, zero hours counts as one,
	// capped at the history depth.
	always_comb begin
		logic [WIN_W:0] raw;
		raw = (window_hours == '0) ? (WIN_W + 1)'(2) : {window_hours, 1'b0};
		if (32'(raw) > HISTORY_DEPTH) begin
			count_d = CNTW'(HISTORY_DEPTH);
		end else begin
			count_d = CNTW'(raw);
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			wptr_q      <= '0;
			rd_ptr_q    <= '0;
			filled_q    <= '0;
			iss_q       <= '0;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			div_cnt_q   <= '0;
			curve_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (take_sample) begin
				wptr_q   <= (wptr_q == HAW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
				rd_ptr_q <= wptr_q;
				iss_q    <= '0;
				count_q  <= count_d;
				if (filled_q != CNTW'(HISTORY_DEPTH)) begin
					filled_q <= filled_q + 1'b1;
				end
			end else if (issue) begin
				rd_ptr_q <= (rd_ptr_q == '0) ? HAW'(HISTORY_DEPTH - 1) : rd_ptr_q - 1'b1;
				iss_q    <= iss_q + 1'b1;
			end
			if (div_init) begin
				div_cnt_q <= '0;
			end else if (div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (take_curve) begin
				curve_vld_q[q_head.item.idx] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// History memory: one write per sample, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (take_sample) begin
			hist_mem[wptr_q] <= q_head.item.temp;
		end
		hist_rd_s1 <= hist_mem[rd_ptr_q];
	end

	// Curve memory: written by curve items, read once per sample.
	always_ff @(posedge clk) begin
		if (take_curve) begin
			curve_mem[q_head.item.idx] <= q_head.item.val;
		end
		if (look) begin
			curve_rd_s1 <= curve_mem[cidx];
			curve_rv_s1 <= curve_vld_q[cidx];
		end
	end

	// Entries older than anything written are read as the first sample.
	assign add_val = use_first_s1 ? first_val_q : hist_rd_s1;

	// Division step: shift in one dividend bit, subtract if it fits.
	assign rem_sh = {rem_q, quo_q[MAGW-1]};
	assign rem_ge = (rem_sh >= {1'b0, count_q});

	// Truncated quotient with the sign restored.
	assign avg_mag = quo_q[TEMP_W-1:0];
	assign avg_d   = neg_q ? (~avg_mag + 1'b1) : avg_mag;
	assign ofs_sum = avg_d + TEMP_W'(CURVE_OFS);

	// Curve entry picked by the average.
	always_comb begin
		if (avg_d > AVG_HI) begin
			cidx = CURVE_IW'(CURVE_LAST);
		end else if (avg_d < AVG_LO) begin
			cidx = '0;
		end else begin
			cidx = ofs_sum[CURVE_IW-1:0];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (take_sample && (filled_q == '0)) begin
			first_val_q <= q_head.item.temp;
		end
		if (issue) begin
			use_first_s1 <= (iss_q >= filled_q);
		end
		if (take_sample) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + {{(SUMW - TEMP_W){add_val[TEMP_W-1]}}, add_val};
		end
		if (div_init) begin
			neg_q <= sum_q[SUMW-1];
			quo_q <= sum_q[SUMW-1] ? MAGW'(-sum_q) : MAGW'(sum_q);
			rem_q <= '0;
		end else if (div_step) begin
			rem_q <= rem_ge ? CNTW'(rem_sh - {1'b0, count_q}) : CNTW'(rem_sh);
			quo_q <= {quo_q[MAGW-2:0], rem_ge};
		end
		if (look) begin
			avg_q <= avg_d;
		end
		if (load_out) begin
			average_temp_q <= avg_q;
			heat_request_q <= curve_rv_s1 ? curve_rd_s1 : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.average_temp = average_temp_q;
	assign out_ch.heat_request = heat_request_q;

endmodule

>>> sv/otahc_checker.sv
// ----------------------------------------------------------------------------
// otahc_checker
// Port-level checks for the heating curve core, bound to the top level.
// ----------------------------------------------------------------------------
module otahc_checker import otahc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                in_mode,
	input  logic                in_reads_valid,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [TEMP_W-1:0]   out_average,
	input  logic [TEMP_W-1:0]   out_heat
);

	logic [3:0] pend_q;
	logic       curve_wr_q;
	logic       sample_in;
	logic       result_out;

	assign sample_in  = in_valid && in_ready && !in_mode && in_reads_valid;
	assign result_out = out_valid && out_ready;

	// Samples accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			curve_wr_q <= 1'b0;
		end else begin
			if (sample_in && !result_out) begin
				pend_q <= pend_q + 1'b1;
			end else if (result_out && !sample_in) begin
				pend_q <= pend_q - 1'b1;
			end
			if (in_valid && in_ready && in_mode) begin
				curve_wr_q <= 1'b1;
			end
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_heat))
		else $error("result changed while stalled");

	// Every result belongs to an accepted valid sample.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without a pending sample");

	// Before any curve write the curve reads as zero.
	a_curve_reset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !curve_wr_q |-> out_heat == '0)
		else $error("heat request not zero before any curve write");

endmodule

bind outside_temp_avg_heat_curve_core otahc_checker u_otahc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.in_mode        (in_ch.mode),
	.in_reads_valid (in_ch.reads_valid),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_average    (out_ch.average_temp),
	.out_heat       (out_ch.heat_request)
);
